@@ hdl/tomt_pkg.sv @@
// package for the ternary opcode match table
// holds field widths, command and status codes and the request/result structs
// no dependencies
package tomt_pkg;

   // default table depth
   localparam int TABLE_DEPTH_DEF = 512;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 9;

   // packed stream widths, filled up to whole bytes
   localparam int REQ_DATA_W = ((CMD_W + 3 * WORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((STATUS_W + INDEX_W + 7) / 8) * 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_HIT  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd3;

   // request handed to the table engine
   typedef struct packed {
      logic              valid;
      logic [CMD_W-1:0]  command;
      logic [WORD_W-1:0] opcode;
      logic [WORD_W-1:0] care_mask;
      logic [WORD_W-1:0] match_value;
   } tomt_req_type;

   // result handed back by the table engine
   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  entry_index;
   } tomt_rsp_type;

endpackage

@@ hdl/ternary_opcode_match_table.sv @@
// top level of the ternary opcode match table: stream ports and result register
// depends on tomt_pkg and tomt_table
//
// channel   direction  payload
// req_      in         command, opcode, care_mask, match_value
// rsp_      out        status, entry_index
//
// clear, append, an unused command and a lookup on an empty table go straight to the
// reply, the result passing from the engine's status register into the output register
// a lookup scans the entries up to and including the first hit, or all entry_count
// entries on a miss, through the single read port of the pattern memory,
// which the scan walks one entry per cycle
// reset is synchronous and clears the entry count; patterns are not erased
// a new request is taken while a result waits in the output register; the
// engine holds its next result until that register is free
module ternary_opcode_match_table #(
   parameter int TABLE_DEPTH = tomt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // command[1:0], opcode[33:2], care_mask[65:34], match_value[97:66]
   input  logic [tomt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[1:0], entry_index[10:2]
   output logic [tomt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tomt_pkg::*;

   tomt_req_type        eng_req;
   tomt_rsp_type        eng_rsp;
   logic                eng_ready;
   logic                out_free;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [INDEX_W-1:0]  index_ff, index_in;

   // unpack the request
   assign eng_req.valid       = req_tvalid && eng_ready;
   assign eng_req.command     = req_tdata[CMD_W-1:0];
   assign eng_req.opcode      = req_tdata[CMD_W+WORD_W-1:CMD_W];
   assign eng_req.care_mask   = req_tdata[CMD_W+2*WORD_W-1:CMD_W+WORD_W];
   assign eng_req.match_value = req_tdata[CMD_W+3*WORD_W-1:CMD_W+2*WORD_W];
   assign req_tready          = eng_ready;

   tomt_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .req       (eng_req),
      .req_ready (eng_ready),
      .rsp       (eng_rsp),
      .rsp_ready (out_free)
   );

   // output register loads when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      index_in     = index_ff;
      if (out_free) begin
         rsp_valid_in = eng_rsp.valid;
         if (eng_rsp.valid) begin
            status_in = eng_rsp.status;
            index_in  = eng_rsp.entry_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      index_ff  <= index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-STATUS_W-INDEX_W){1'b0}}, index_ff, status_ff};

endmodule

@@ hdl/tomt_table.sv @@
// table engine: pattern memory, entry count and the lookup scan sequencer
// depends on tomt_pkg
module tomt_table #(
   parameter int TABLE_DEPTH = tomt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tomt_pkg::tomt_req_type req,
   output logic                  req_ready,
   output tomt_pkg::tomt_rsp_type rsp,
   input  logic                  rsp_ready
);
   import tomt_pkg::*;

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_REPLY
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   scan_addr_ff, scan_addr_in;
   logic                issue_en_ff, issue_en_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic                cmp_last_ff, cmp_last_in;
   logic [ADDR_W-1:0]   cmp_addr_ff, cmp_addr_in;
   logic [WORD_W-1:0]   opcode_ff, opcode_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [INDEX_W-1:0]  index_ff, index_in;

   // pattern memory, mask and value side by side
   logic [2*WORD_W-1:0] mem [TABLE_DEPTH];
   logic [2*WORD_W-1:0] rd_data_ff;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;

   logic                table_full;
   logic                issue_last;
   logic                hit;
   logic [ADDR_W+INDEX_W-1:0] cmp_addr_ext;

   assign table_full   = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign issue_last   = ((CNT_W'(scan_addr_ff) + CNT_W'(1)) == count_ff);
   assign hit          = (((opcode_ff ^ rd_data_ff[WORD_W-1:0])
                           & rd_data_ff[2*WORD_W-1:WORD_W]) == '0);
   assign cmp_addr_ext = {{INDEX_W{1'b0}}, cmp_addr_ff};
   assign wr_addr      = count_ff[ADDR_W-1:0];
   assign wr_en        = (state_ff == S_IDLE) && req.valid &&
                         (req.command == CMD_APPEND) && !table_full;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req.care_mask, req.match_value};
      end
      rd_data_ff <= mem[scan_addr_ff];
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      issue_en_in  = issue_en_ff;
      cmp_valid_in = 1'b0;
      cmp_last_in  = cmp_last_ff;
      cmp_addr_in  = cmp_addr_ff;
      opcode_in    = opcode_ff;
      status_in    = status_ff;
      index_in     = index_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               status_in = STAT_DONE;
               index_in  = '0;
               state_in  = S_REPLY;
               case (req.command)
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_APPEND: begin
                     if (table_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_LOOKUP: begin
                     status_in    = STAT_MISS;
                     opcode_in    = req.opcode;
                     scan_addr_in = '0;
                     issue_en_in  = 1'b1;
                     if (count_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     status_in = STAT_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // issue one read per cycle until the last valid entry
            if (issue_en_ff) begin
               cmp_valid_in = 1'b1;
               cmp_addr_in  = scan_addr_ff;
               cmp_last_in  = issue_last;
               scan_addr_in = scan_addr_ff + ADDR_W'(1);
               issue_en_in  = !issue_last;
            end
            // compare the entry read last cycle
            if (cmp_valid_ff) begin
               if (hit) begin
                  status_in = STAT_HIT;
                  index_in  = cmp_addr_ext[INDEX_W-1:0];
                  state_in  = S_REPLY;
               end else if (cmp_last_ff) begin
                  status_in = STAT_MISS;
                  state_in  = S_REPLY;
               end
            end
         end
         S_REPLY: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_en_ff  <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_en_ff  <= issue_en_in;
         cmp_valid_ff <= cmp_valid_in;
      end
      scan_addr_ff <= scan_addr_in;
      cmp_last_ff  <= cmp_last_in;
      cmp_addr_ff  <= cmp_addr_in;
      opcode_ff    <= opcode_in;
      status_ff    <= status_in;
      index_ff     <= index_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp.valid       = (state_ff == S_REPLY);
   assign rsp.status      = status_ff;
   assign rsp.entry_index = index_ff;

endmodule
